// ===== sv/gimbal_rate_p_controller_macros.svh =====
// Assertion macros for the gimbal rate controller.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef GIMBAL_RATE_P_CONTROLLER_MACROS_SVH
`define GIMBAL_RATE_P_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
`define GRPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GRPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define GRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/grpc_pkg.sv =====
`timescale 1ns / 1ps

package grpc_pkg;

	localparam int POS_W     = 15;
	localparam int WANT_W    = 16;
	localparam int RATE_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int LIM_W     = 15;
	localparam int BAND_W    = 15;
	localparam int WT_W      = 17;
	localparam int ERR_W     = 18;
	localparam int PROD_W    = 36;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic [POS_W-1:0] ONE_Q14 = 15'd16384;
	localparam logic [WT_W-1:0]  ONE_Q16 = 17'd65536;

	localparam logic [GAIN_W-1:0] GAIN_YAW_RST    = 16'd4915;
	localparam logic [GAIN_W-1:0] GAIN_PITCH_RST  = 16'd3686;
	localparam logic [LIM_W-1:0]  LIMIT_YAW_RST   = 15'd6144;
	localparam logic [LIM_W-1:0]  LIMIT_PITCH_RST = 15'd4096;
	localparam logic [BAND_W-1:0] ERROR_BAND_RST  = 15'd246;
	localparam logic [WT_W-1:0]   SMOOTHING_RST   = 17'd22938;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_YAW       = 3'd0,
		CFG_GAIN_PITCH     = 3'd1,
		CFG_LIMIT_YAW      = 3'd2,
		CFG_LIMIT_PITCH    = 3'd3,
		CFG_ERROR_BAND     = 3'd4,
		CFG_SMOOTHING      = 3'd5,
		CFG_HOLD_WHEN_LOST = 3'd6
	} cfg_reg_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MY    = 8'b0000_0010,
		S_MP    = 8'b0000_0100,
		S_RP_FY = 8'b0000_1000,
		S_FY    = 8'b0001_0000,
		S_FP    = 8'b0010_0000,
		S_RF    = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// Negated doubled error, 2*(clamp(want) - target), with the deadband applied.
	function automatic logic signed [ERR_W-1:0] err_neg(
		input logic [POS_W-1:0]         tgt,
		input logic signed [WANT_W-1:0] want,
		input logic [BAND_W-1:0]        band
	);
		logic [POS_W-1:0]        d;
		logic signed [ERR_W-1:0] e;
		logic [ERR_W-1:0]        mag;
		if (want < 0) begin
			d = '0;
		end else if (want > 16'sd16384) begin
			d = ONE_Q14;
		end else begin
			d = want[POS_W-1:0];
		end
		e   = {2'b00, d, 1'b0} - {2'b00, tgt, 1'b0};
		mag = e[ERR_W-1] ? (ERR_W'(0) - e) : e;
		if (mag < {3'b000, band}) begin
			e = '0;
		end
		return e;
	endfunction

	// Configured limit, tightened by a nonzero per-tick cap.
	function automatic logic [LIM_W-1:0] rate_lim(
		input logic [LIM_W-1:0] limit,
		input logic [LIM_W-1:0] cap
	);
		return (cap != '0 && cap < limit) ? cap : limit;
	endfunction

endpackage

// ===== sv/gimbal_rate_p_controller.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        receive    in_valid / in_stall  ready_req tracking_on target_u target_v
//                                           want_u want_v cap_yaw cap_pitch
// out       send       out_valid / out_stall yaw_cmd pitch_cmd hold
// cfg       receive    cfg_we               cfg_index cfg_data
//
// A tracking tick steps through MY, MP, RP_FY, FP and RF before DONE: one shared
// 18x18 multiplier and one rounding/clamp unit serve four products in turn.
// A tick that holds on loss goes straight to DONE; a decaying tick runs only the filter products.
// in_stall is high from acceptance until the result is loaded into the output register.
// A result waits in the output register under out_stall; the next transaction is then
// taken but its result is held until the register frees.
// Reset clears the filter memories and restores the register defaults.

`include "gimbal_rate_p_controller_macros.svh"

module gimbal_rate_p_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  ready_req,
	input  logic                                  tracking_on,
	input  logic [grpc_pkg::POS_W-1:0]            target_u,
	input  logic [grpc_pkg::POS_W-1:0]            target_v,
	input  logic signed [grpc_pkg::WANT_W-1:0]    want_u,
	input  logic signed [grpc_pkg::WANT_W-1:0]    want_v,
	input  logic [grpc_pkg::LIM_W-1:0]            cap_yaw,
	input  logic [grpc_pkg::LIM_W-1:0]            cap_pitch,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [grpc_pkg::RATE_W-1:0]    yaw_cmd,
	output logic signed [grpc_pkg::RATE_W-1:0]    pitch_cmd,
	output logic                                  hold,
	input  logic                                  cfg_we,
	input  logic [grpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [grpc_pkg::CFG_W-1:0]            cfg_data
);

	// configuration
	logic [grpc_pkg::GAIN_W-1:0] gain_yaw_q, gain_pitch_q;
	logic [grpc_pkg::LIM_W-1:0]  limit_yaw_q, limit_pitch_q;
	logic [grpc_pkg::BAND_W-1:0] error_band_q;
	logic [grpc_pkg::WT_W-1:0]   smoothing_q;
	logic                        hold_when_lost_q;

	// working registers
	grpc_pkg::state_t                        state_q;
	logic signed [grpc_pkg::ERR_W-1:0]       errn_y_q, errn_p_q;
	logic [grpc_pkg::LIM_W-1:0]              lim_y_q, lim_p_q;
	logic signed [grpc_pkg::RATE_W-1:0]      rate_y_q, rate_p_q;
	logic signed [grpc_pkg::RATE_W-1:0]      last_y_q, last_p_q;
	logic signed [grpc_pkg::PROD_W-1:0]      prod_q;
	logic                                    hold_flag_q;
	logic                                    out_valid_q;
	logic signed [grpc_pkg::RATE_W-1:0]      yaw_cmd_q, pitch_cmd_q;
	logic                                    hold_q;

	logic                              in_acc, active, out_fire, out_load;
	logic [grpc_pkg::WT_W-1:0]         wt;
	logic signed [grpc_pkg::RATE_W:0]  diff_y, diff_p;
	logic [grpc_pkg::WT_W-1:0]         mul_a;
	logic signed [grpc_pkg::ERR_W-1:0] mul_as, mul_b;
	logic signed [grpc_pkg::PROD_W-1:0] mul_res;

	// rounding unit
	logic                               rnd_f;
	logic signed [grpc_pkg::RATE_W-1:0] rnd_prev;
	logic [grpc_pkg::LIM_W-1:0]         rnd_plim;
	logic signed [grpc_pkg::PROD_W-1:0] rnd_in;
	logic                               rnd_neg;
	logic [grpc_pkg::PROD_W-1:0]        rnd_mag, rnd_sum, rnd_shf;
	logic [grpc_pkg::WT_W-1:0]          rnd_lim, rnd_mcl, rnd_r17;
	logic signed [grpc_pkg::RATE_W-1:0] rnd_out;

	assign in_stall = (state_q != grpc_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign active   = ready_req && tracking_on;
	assign out_fire = out_valid_q && !out_stall;
	assign out_load = (state_q == grpc_pkg::S_DONE) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign yaw_cmd   = yaw_cmd_q;
	assign pitch_cmd = pitch_cmd_q;
	assign hold      = hold_q;

	assign wt = (smoothing_q > grpc_pkg::ONE_Q16) ? grpc_pkg::ONE_Q16 : smoothing_q;

	// filter is evaluated as prev + a*(cur - prev)
	assign diff_y = {rate_y_q[grpc_pkg::RATE_W-1], rate_y_q}
		- {last_y_q[grpc_pkg::RATE_W-1], last_y_q};
	assign diff_p = {rate_p_q[grpc_pkg::RATE_W-1], rate_p_q}
		- {last_p_q[grpc_pkg::RATE_W-1], last_p_q};

	always_comb begin
		unique case (state_q) inside
			grpc_pkg::S_MY: begin
				mul_a = {1'b0, gain_yaw_q};
				mul_b = errn_y_q;
			end
			grpc_pkg::S_MP: begin
				mul_a = {1'b0, gain_pitch_q};
				mul_b = errn_p_q;
			end
			grpc_pkg::S_RP_FY, grpc_pkg::S_FY: begin
				mul_a = wt;
				mul_b = {diff_y[grpc_pkg::RATE_W], diff_y};
			end
			grpc_pkg::S_FP: begin
				mul_a = wt;
				mul_b = {diff_p[grpc_pkg::RATE_W], diff_p};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_as  = {1'b0, mul_a};
	assign mul_res = mul_as * mul_b;

	// Round magnitude to nearest, ties away from zero, then clamp.
	always_comb begin
		rnd_f    = (state_q == grpc_pkg::S_FP) || (state_q == grpc_pkg::S_RF);
		rnd_prev = (state_q == grpc_pkg::S_FP) ? last_y_q : last_p_q;
		rnd_plim = (state_q == grpc_pkg::S_MP) ? lim_y_q : lim_p_q;
		if (rnd_f) begin
			rnd_in = prod_q + {{4{rnd_prev[grpc_pkg::RATE_W-1]}}, rnd_prev, 16'h0000};
		end else begin
			rnd_in = prod_q;
		end
		rnd_neg = rnd_in[grpc_pkg::PROD_W-1];
		rnd_mag = rnd_neg ? (grpc_pkg::PROD_W'(0) - rnd_in) : rnd_in;
		if (rnd_f) begin
			rnd_sum = rnd_mag + 36'd32768;
			rnd_shf = rnd_sum >> 16;
			rnd_lim = rnd_neg ? 17'd32768 : 17'd32767;
		end else begin
			rnd_sum = rnd_mag + 36'd8192;
			rnd_shf = rnd_sum >> 14;
			rnd_lim = {2'b00, rnd_plim};
		end
		rnd_mcl = (rnd_shf > {19'd0, rnd_lim}) ? rnd_lim : rnd_shf[grpc_pkg::WT_W-1:0];
		rnd_r17 = rnd_neg ? (17'd0 - rnd_mcl) : rnd_mcl;
		rnd_out = rnd_r17[grpc_pkg::RATE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_yaw_q       <= grpc_pkg::GAIN_YAW_RST;
			gain_pitch_q     <= grpc_pkg::GAIN_PITCH_RST;
			limit_yaw_q      <= grpc_pkg::LIMIT_YAW_RST;
			limit_pitch_q    <= grpc_pkg::LIMIT_PITCH_RST;
			error_band_q     <= grpc_pkg::ERROR_BAND_RST;
			smoothing_q      <= grpc_pkg::SMOOTHING_RST;
			hold_when_lost_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grpc_pkg::CFG_GAIN_YAW:       gain_yaw_q       <= cfg_data[grpc_pkg::GAIN_W-1:0];
				grpc_pkg::CFG_GAIN_PITCH:     gain_pitch_q     <= cfg_data[grpc_pkg::GAIN_W-1:0];
				grpc_pkg::CFG_LIMIT_YAW:      limit_yaw_q      <= cfg_data[grpc_pkg::LIM_W-1:0];
				grpc_pkg::CFG_LIMIT_PITCH:    limit_pitch_q    <= cfg_data[grpc_pkg::LIM_W-1:0];
				grpc_pkg::CFG_ERROR_BAND:     error_band_q     <= cfg_data[grpc_pkg::BAND_W-1:0];
				grpc_pkg::CFG_SMOOTHING:      smoothing_q      <= cfg_data;
				grpc_pkg::CFG_HOLD_WHEN_LOST: hold_when_lost_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grpc_pkg::S_IDLE;
			errn_y_q    <= '0;
			errn_p_q    <= '0;
			lim_y_q     <= '0;
			lim_p_q     <= '0;
			rate_y_q    <= '0;
			rate_p_q    <= '0;
			last_y_q    <= '0;
			last_p_q    <= '0;
			prod_q      <= '0;
			hold_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
			yaw_cmd_q   <= '0;
			pitch_cmd_q <= '0;
			hold_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				yaw_cmd_q   <= last_y_q;
				pitch_cmd_q <= last_p_q;
				hold_q      <= hold_flag_q;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				grpc_pkg::S_IDLE: begin
					if (in_acc) begin
						errn_y_q <= grpc_pkg::err_neg(target_u, want_u, error_band_q);
						errn_p_q <= grpc_pkg::err_neg(target_v, want_v, error_band_q);
						lim_y_q  <= grpc_pkg::rate_lim(limit_yaw_q, cap_yaw);
						lim_p_q  <= grpc_pkg::rate_lim(limit_pitch_q, cap_pitch);
						if (active) begin
							hold_flag_q <= 1'b0;
							state_q     <= grpc_pkg::S_MY;
						end else if (hold_when_lost_q) begin
							last_y_q    <= '0;
							last_p_q    <= '0;
							hold_flag_q <= 1'b1;
							state_q     <= grpc_pkg::S_DONE;
						end else begin
							// decay toward zero
							rate_y_q    <= '0;
							rate_p_q    <= '0;
							hold_flag_q <= 1'b0;
							state_q     <= grpc_pkg::S_FY;
						end
					end
				end
				grpc_pkg::S_MY: begin
					prod_q  <= mul_res;
					state_q <= grpc_pkg::S_MP;
				end
				grpc_pkg::S_MP: begin
					prod_q   <= mul_res;
					rate_y_q <= rnd_out;
					state_q  <= grpc_pkg::S_RP_FY;
				end
				grpc_pkg::S_RP_FY: begin
					prod_q   <= mul_res;
					rate_p_q <= rnd_out;
					state_q  <= grpc_pkg::S_FP;
				end
				grpc_pkg::S_FY: begin
					prod_q  <= mul_res;
					state_q <= grpc_pkg::S_FP;
				end
				grpc_pkg::S_FP: begin
					prod_q   <= mul_res;
					last_y_q <= rnd_out;
					state_q  <= grpc_pkg::S_RF;
				end
				grpc_pkg::S_RF: begin
					last_p_q <= rnd_out;
					state_q  <= grpc_pkg::S_DONE;
				end
				grpc_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= grpc_pkg::S_IDLE;
					end
				end
				default: state_q <= grpc_pkg::S_IDLE;
			endcase
		end
	end

	`GRPC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_acc, in_stall, "transaction taken while busy")
	`GRPC_ASSERT_NEXT(a_hold_clears, clk, arst_n, in_acc && !active && hold_when_lost_q, last_y_q == '0 && last_p_q == '0 && hold_flag_q, "hold on loss did not clear filter memory")
	`GRPC_ASSERT_SAME(a_hold_zero, clk, arst_n, out_valid_q && hold_q, yaw_cmd_q == '0 && pitch_cmd_q == '0, "held result carries nonzero rate")
	`GRPC_ASSERT_NEXT(a_done_loads, clk, arst_n, out_load, out_valid_q && state_q == grpc_pkg::S_IDLE, "finished result not presented")
	`GRPC_ASSERT_SAME(a_rate_y_lim, clk, arst_n, state_q == grpc_pkg::S_RP_FY, $signed({rate_y_q[grpc_pkg::RATE_W-1], rate_y_q}) <= $signed({2'b00, lim_y_q}) && $signed({rate_y_q[grpc_pkg::RATE_W-1], rate_y_q}) >= -$signed({2'b00, lim_y_q}), "yaw rate beyond limit")

endmodule
